>>> sv/ceht_pkg.sv
// ceht_pkg: shared types, codes and constant tables for the clock enable hold tracker.
// No dependencies; imported by ceht_front, ceht_queue, ceht_back, the top level and the bench.
package ceht_pkg;

    // Widest clock id the block supports (12 bits, up to 4096 ids).
    localparam int ID_W_MAX = 12;

    localparam int ACTION_W = 3;
    localparam int ARG_W    = 32;
    localparam int STATUS_W = 3;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_CLK_ON   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CLK_OFF  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RAIL_ON  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RAIL_OFF = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_SDC_SEL  = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLOCK_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RAIL_RANGE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RAIL_NONE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_AMBIGUOUS   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_SEL     = 3'd6;

    // Rail table size is fixed; rails past it have no clock.
    localparam int RAIL_TABLE_SIZE = 10;

    // Allowed SD-card clock selections
    localparam logic [ARG_W-1:0] SDC_SEL_A = 32'd0;
    localparam logic [ARG_W-1:0] SDC_SEL_B = 32'd6;
    localparam logic [ARG_W-1:0] SDC_SEL_C = 32'd7;
    localparam logic [ARG_W-1:0] SDC_SEL_D = 32'd9;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ARG_W-1:0]    argument;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                enabled;
    } result_t;

    // Work handed from the front end to the table engine
    typedef enum logic [1:0] {
        OP_NONE,
        OP_ENABLE,
        OP_DISABLE,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [ID_W_MAX-1:0] id;
        logic [STATUS_W-1:0] status;
    } q_entry_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_MODIFY
    } back_state_t;

    // Rail number to clock id; zero means the rail has no clock.
    function automatic logic [ARG_W-1:0] rail_clock(input logic [3:0] rail);
        logic [ARG_W-1:0] clk_id;
        unique case (rail)
            4'd1:    clk_id = 32'd187;
            4'd2:    clk_id = 32'd110;
            4'd3:    clk_id = 32'd61;
            4'd4:    clk_id = 32'd39;
            4'd5:    clk_id = 32'd52;
            4'd6:    clk_id = 32'd112;
            4'd7:    clk_id = 32'd92;
            4'd8:    clk_id = 32'd29;
            4'd9:    clk_id = 32'd189;
            default: clk_id = 32'd0;
        endcase
        return clk_id;
    endfunction

endpackage

>>> sv/ceht_ram.sv
// ceht_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ceht_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 375
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/ceht_front.sv
// ceht_front: request acceptance and classification (range checks, rail lookup,
// sd-card selection check). Depends on ceht_pkg.
module ceht_front
    import ceht_pkg::*;
#(
    parameter int NUM_CLOCKS = 375,
    parameter int NUM_RAILS  = 10
) (
    input  logic     start,
    input  cmd_t     cmd,
    input  logic     q_full,
    input  logic     clearing,
    output logic     busy,
    output logic     push,
    output q_entry_t entry
);
    logic [ARG_W-1:0] rail_clk;
    logic             clk_oor;
    logic             rail_clk_oor;

    assign busy = clearing | q_full;
    assign push = start & ~busy;

    assign rail_clk     = rail_clock(cmd.argument[3:0]);
    assign clk_oor      = cmd.argument >= ARG_W'(NUM_CLOCKS);
    assign rail_clk_oor = rail_clk >= ARG_W'(NUM_CLOCKS);

    always_comb
    begin
        entry.op     = OP_NONE;
        entry.id     = '0;
        entry.status = ST_OK;
        unique case (cmd.action) inside
            ACT_CLK_ON, ACT_CLK_OFF:
            begin
                if (clk_oor)
                begin
                    entry.status = ST_CLOCK_RANGE;
                end
                else
                begin
                    entry.op = (cmd.action == ACT_CLK_ON) ? OP_ENABLE : OP_DISABLE;
                    entry.id = cmd.argument[ID_W_MAX-1:0];
                end
            end
            ACT_RAIL_ON, ACT_RAIL_OFF:
            begin
                if (cmd.argument >= ARG_W'(NUM_RAILS))
                begin
                    entry.status = ST_RAIL_RANGE;
                end
                else if (cmd.argument >= ARG_W'(RAIL_TABLE_SIZE) || rail_clk == '0)
                begin
                    entry.status = ST_RAIL_NONE;
                end
                else if (rail_clk_oor)
                begin
                    entry.status = ST_CLOCK_RANGE;
                end
                else
                begin
                    entry.op = (cmd.action == ACT_RAIL_ON) ? OP_ENABLE : OP_DISABLE;
                    entry.id = rail_clk[ID_W_MAX-1:0];
                end
            end
            ACT_QUERY:
            begin
                if (clk_oor)
                begin
                    entry.status = ST_CLOCK_RANGE;
                end
                else
                begin
                    entry.op = OP_QUERY;
                    entry.id = cmd.argument[ID_W_MAX-1:0];
                end
            end
            ACT_SDC_SEL:
            begin
                if (cmd.argument == SDC_SEL_A || cmd.argument == SDC_SEL_B ||
                    cmd.argument == SDC_SEL_C || cmd.argument == SDC_SEL_D)
                begin
                    entry.status = ST_OK;
                end
                else
                begin
                    entry.status = ST_BAD_SEL;
                end
            end
            default:
            begin
                entry.status = ST_OK;
            end
        endcase
    end

endmodule

>>> sv/ceht_queue.sv
// ceht_queue: two-word FIFO between the front end and the table engine.
// Depends on ceht_pkg.
module ceht_queue
    import ceht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t wdata,
    input  logic     pop,
    output q_entry_t rdata,
    output logic     empty,
    output logic     full
);
    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    q_entry_t         slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/ceht_back.sv
// ceht_back: table engine; clears the clock table after reset, then does one
// read-modify-write per enable/disable word, a read per query, and drives the
// result strobe for every word. Depends on ceht_pkg and ceht_ram.
module ceht_back
    import ceht_pkg::*;
#(
    parameter int NUM_CLOCKS  = 375,
    parameter int COUNT_WIDTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  q_entry_t q_data,
    input  logic     q_empty,
    output logic     pop,
    output logic     clearing,
    output logic     done,
    output result_t  result
);
    localparam int AW = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
    localparam int WW = COUNT_WIDTH + 2;   // {ambiguous, known, count}

    back_state_t      state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    q_entry_t         ent_reg, ent_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [WW-1:0]    wdata;
    logic [AW-1:0]    raddr;
    logic [WW-1:0]    rdata;

    logic                   rd_amb;
    logic                   rd_known;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic                   nx_amb;
    logic [COUNT_WIDTH-1:0] nx_cnt;

    ceht_ram #(
        .WIDTH (WW),
        .DEPTH (NUM_CLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_amb   = rdata[WW-1];
    assign rd_known = rdata[WW-2];
    assign rd_cnt   = rdata[COUNT_WIDTH-1:0];

    // Hold count update; an ambiguous entry keeps its count.
    always_comb
    begin
        nx_amb = rd_amb;
        nx_cnt = rd_cnt;
        if (!rd_amb)
        begin
            if (ent_reg.op == OP_ENABLE)
            begin
                if (rd_cnt == '1)
                begin
                    nx_amb = 1'b1;
                end
                else
                begin
                    nx_cnt = rd_cnt + 1'b1;
                end
            end
            else
            begin
                if (rd_cnt > COUNT_WIDTH'(1))
                begin
                    nx_amb = 1'b1;
                end
                else
                begin
                    nx_cnt = '0;
                end
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                if (clr_addr_reg == AW'(NUM_CLOCKS - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty && q_data.op != OP_NONE)
                begin
                    state_next = BK_MODIFY;
                end
            end
            BK_MODIFY:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        we            = 1'b0;
        waddr         = clr_addr_reg;
        wdata         = '0;
        raddr         = q_data.id[AW-1:0];
        pop           = 1'b0;
        clr_addr_next = clr_addr_reg;
        ent_next      = ent_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                we            = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    ent_next = q_data;
                    if (q_data.op == OP_NONE)
                    begin
                        done_next           = 1'b1;
                        result_next.status  = q_data.status;
                        result_next.enabled = 1'b0;
                    end
                end
            end
            BK_MODIFY:
            begin
                done_next = 1'b1;
                waddr     = ent_reg.id[AW-1:0];
                if (ent_reg.op == OP_QUERY)
                begin
                    result_next.enabled = 1'b0;
                    if (rd_amb)
                    begin
                        result_next.status = ST_AMBIGUOUS;
                    end
                    else if (!rd_known)
                    begin
                        result_next.status = ST_UNKNOWN;
                    end
                    else
                    begin
                        result_next.status  = ST_OK;
                        result_next.enabled = (rd_cnt != '0);
                    end
                end
                else
                begin
                    we                  = 1'b1;
                    wdata               = {nx_amb, 1'b1, nx_cnt};
                    result_next.status  = ST_OK;
                    result_next.enabled = 1'b0;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg    <= ent_next;
        result_reg <= result_next;
    end

    assign clearing = (state_reg == BK_CLEAR);
    assign done     = done_reg;
    assign result   = result_reg;

endmodule

>>> sv/clock_enable_hold_tracker.sv
// clock_enable_hold_tracker: top level; front end, two-word queue and table engine.
// Depends on ceht_pkg, ceht_front, ceht_queue, ceht_back (and ceht_ram below it).
//
// Tracks a hold count, an ambiguous mark and a known mark for each of
// NUM_CLOCKS clock ids. A request is taken on a clock edge with start high and
// busy low; exactly one result comes back for each request, in request order,
// as a one-cycle done pulse with status/enabled on result. The receiver cannot
// stall: sample result whenever done is high. After reset the block runs a
// clearing pass over the clock table, one entry per cycle, and busy stays high
// until the pass is over. In the table engine a request that touches the table
// (enable, disable, query) has its entry read from the RAM in BK_IDLE; in
// BK_MODIFY an enable or disable writes the entry back, and the result is
// driven for all three. Requests that fail a range check, sd-card selection
// checks and unused actions are answered from BK_IDLE with no table access.
// The front end classifies a request in the cycle it is taken and parks it in
// a two-word queue; busy is high only while clearing or while that queue is full.
// Status codes: 0 ok, 1 clock out of range, 2 rail out of range, 3 rail has no
// clock, 4 count ambiguous, 5 unknown id, 6 bad sdc selection. A failed
// request leaves the table untouched. enabled is 1 only for a successful query
// of a clock whose count is nonzero.
module clock_enable_hold_tracker
    import ceht_pkg::*;
#(
    parameter int NUM_CLOCKS  = 375,
    parameter int COUNT_WIDTH = 16,
    parameter int NUM_RAILS   = 10
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);
    q_entry_t push_word;
    q_entry_t pop_word;
    logic     push;
    logic     pop;
    logic     q_empty;
    logic     q_full;
    logic     clearing;

    // Classify on accept; no table access here.
    ceht_front #(
        .NUM_CLOCKS (NUM_CLOCKS),
        .NUM_RAILS  (NUM_RAILS)
    ) u_front (
        .start    (start),
        .cmd      (cmd),
        .q_full   (q_full),
        .clearing (clearing),
        .busy     (busy),
        .push     (push),
        .entry    (push_word)
    );

    // Every request goes through the queue so results stay in order.
    ceht_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_word),
        .pop   (pop),
        .rdata (pop_word),
        .empty (q_empty),
        .full  (q_full)
    );

    // Table engine: clearing pass, then a read-modify-write per enable/disable word.
    ceht_back #(
        .NUM_CLOCKS  (NUM_CLOCKS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (pop_word),
        .q_empty  (q_empty),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

    // No result while the table is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !done)
        else $error("result strobe during clearing pass");

    // enabled only ever accompanies an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.enabled) |-> (result.status == ST_OK))
        else $error("enabled set with non-ok status");

    // Nothing enters the queue before the clearing pass ends.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !clearing)
        else $error("request accepted during clearing pass");

    // The engine only pops a word that is there.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule

>>> test/clock_enable_hold_tracker_tb.sv
// clock_enable_hold_tracker_tb: self-checking bench for the clock enable hold tracker.
// Needs ceht_pkg and the clock_enable_hold_tracker RTL; it reads and writes no files.
// Covers directed corner cases, hold count saturation and random request traffic.
module clock_enable_hold_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ceht_pkg::*;

    localparam int N_CLK  = 375;
    // Narrow count so saturation takes only a handful of enables
    localparam int CNT_W  = 4;
    localparam int N_RAIL = 10;

    // Actions the block must answer with ok and leave state alone
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    // Rail number -> clock id, rail 0 in the low word; zero means no clock
    localparam logic [RAIL_TABLE_SIZE*32-1:0] RAIL_MAP = {
        32'd189, 32'd29, 32'd92, 32'd112, 32'd52,
        32'd39, 32'd61, 32'd110, 32'd187, 32'd0
    };

    // Clock driven to the top of its hold count
    localparam logic [ARG_W-1:0] SAT_ID = 32'd300;

    localparam int N_RANDOM   = 700;
    localparam int QUIET_TAIL = 100;

    localparam logic FIXED = 1'b1;
    localparam logic PRED  = 1'b0;

    typedef struct packed {
        cmd_t    c;
        logic    chk;
        result_t r;
    } row_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    // Typed-in expectation travels with the word it belongs to
    logic    fix_on  = 1'b0;
    result_t fix_res = '0;

    // Shadow of the clock table
    bit [CNT_W-1:0] hold_cnt [N_CLK];
    bit             amb_mark [N_CLK];
    bit             known    [N_CLK];

    result_t results_due [$];
    row_t    dir_rows [$];

    int n_err     = 0;
    int n_acc     = 0;
    int n_checked = 0;
    int st_seen [8];

    clock_enable_hold_tracker #(
        .NUM_CLOCKS (N_CLK),
        .COUNT_WIDTH(CNT_W),
        .NUM_RAILS  (N_RAIL)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Enable or disable one clock id in the shadow table; returns the status.
    // An ambiguous entry only picks up the known mark.
    function automatic logic [STATUS_W-1:0] hold_update(logic [ARG_W-1:0] id, bit on);
        if (id >= 32'(N_CLK))
            return ST_CLOCK_RANGE;
        known[id] = 1'b1;
        if (amb_mark[id])
            return ST_OK;
        if (on)
        begin
            // enable at the top of the count: count stays, entry goes ambiguous
            if (hold_cnt[id] == '1)
                amb_mark[id] = 1'b1;
            else
                hold_cnt[id] = hold_cnt[id] + 1'b1;
        end
        else
        begin
            if (hold_cnt[id] > 1)
                amb_mark[id] = 1'b1;
            else
                hold_cnt[id] = '0;
        end
        return ST_OK;
    endfunction

    // Expected answer to one request; updates the shadow table.
    function automatic result_t apply_request(cmd_t c);
        result_t          r;
        logic [ARG_W-1:0] clk_id;
        r.status  = ST_OK;
        r.enabled = 1'b0;
        case (c.action)
            ACT_CLK_ON, ACT_CLK_OFF:
                r.status = hold_update(c.argument, c.action == ACT_CLK_ON);
            ACT_RAIL_ON, ACT_RAIL_OFF:
            begin
                if (c.argument >= 32'(N_RAIL))
                    r.status = ST_RAIL_RANGE;
                else if (c.argument >= 32'(RAIL_TABLE_SIZE))
                    r.status = ST_RAIL_NONE;
                else
                begin
                    clk_id = RAIL_MAP[c.argument[3:0]*32 +: 32];
                    if (clk_id == '0)
                        r.status = ST_RAIL_NONE;
                    else
                        r.status = hold_update(clk_id, c.action == ACT_RAIL_ON);
                end
            end
            ACT_QUERY:
            begin
                // range first, then ambiguous, then unknown
                if (c.argument >= 32'(N_CLK))
                    r.status = ST_CLOCK_RANGE;
                else if (amb_mark[c.argument])
                    r.status = ST_AMBIGUOUS;
                else if (!known[c.argument])
                    r.status = ST_UNKNOWN;
                else
                    r.enabled = (hold_cnt[c.argument] != '0);
            end
            ACT_SDC_SEL:
            begin
                if (c.argument == SDC_SEL_A || c.argument == SDC_SEL_B ||
                    c.argument == SDC_SEL_C || c.argument == SDC_SEL_D)
                    r.status = ST_OK;
                else
                    r.status = ST_BAD_SEL;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // Random request word. Clock ids mostly come from a window of eight ids
    // starting at base so that counts build up and queries find known entries.
    function automatic cmd_t random_word(int base);
        cmd_t c;
        int   p;
        int   k;
        p = $urandom_range(99);
        k = $urandom_range(15);
        if (p < 25)
            c.action = ACT_CLK_ON;
        else if (p < 40)
            c.action = ACT_CLK_OFF;
        else if (p < 50)
            c.action = ACT_RAIL_ON;
        else if (p < 58)
            c.action = ACT_RAIL_OFF;
        else if (p < 83)
            c.action = ACT_QUERY;
        else if (p < 93)
            c.action = ACT_SDC_SEL;
        else if (p < 96)
            c.action = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
        else
            c.action = 3'($urandom_range(7));

        if (p >= 96 || k == 15)
            c.argument = $urandom();
        else if (c.action == ACT_RAIL_ON || c.action == ACT_RAIL_OFF)
            c.argument = $urandom_range(12);
        else if (c.action == ACT_SDC_SEL)
            c.argument = $urandom_range(10);
        else if (k < 10)
            c.argument = (base + $urandom_range(7)) % N_CLK;
        else if (k < 13)
            c.argument = $urandom_range(N_CLK - 1);
        else
            c.argument = $urandom_range(N_CLK + 7, N_CLK);
        return c;
    endfunction

    task automatic row(logic [ACTION_W-1:0] a, logic [ARG_W-1:0] arg, logic chk,
                       logic [STATUS_W-1:0] st, logic en);
        dir_rows.push_back({a, arg, chk, st, en});
    endtask

    // Present one word after an optional idle burst; returns at the edge
    // that takes it, with start still high.
    task automatic send_word(cmd_t c, logic chk, result_t r, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        cmd     <= c;
        fix_on  <= chk;
        fix_res <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold off until every expected result word has come back.
    task automatic wait_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (results_due.size() != 0);
        @(posedge clk);
    endtask

    // Scoreboard: check the result word first, then log a newly taken request.
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d enabled %0b",
                           result.status, result.enabled);
                    n_err++;
                end
                else
                begin
                    want = results_due.pop_front();
                    n_checked++;
                    st_seen[want.status]++;
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        n_err++;
                    end
                    if (result.enabled !== want.enabled)
                    begin
                        $error("enabled: expected %0b, got %0b", want.enabled, result.enabled);
                        n_err++;
                    end
                end
            end
            if (start && !busy)
            begin
                want = apply_request(cmd);
                if (fix_on)
                    want = fix_res;
                results_due.push_back(want);
                n_acc++;
            end
        end
    end

    initial
    begin : stimulus
        int base;
        int gap;

        // action           argument       check  status          enabled
        row(ACT_QUERY,      32'd0,          FIXED, ST_UNKNOWN,     1'b0);
        row(ACT_QUERY,      32'd374,        FIXED, ST_UNKNOWN,     1'b0);
        row(ACT_QUERY,      32'd375,        FIXED, ST_CLOCK_RANGE, 1'b0);
        row(ACT_QUERY,      32'hFFFF_FFFF,  FIXED, ST_CLOCK_RANGE, 1'b0);
        row(ACT_CLK_ON,     32'd375,        FIXED, ST_CLOCK_RANGE, 1'b0);
        row(ACT_CLK_OFF,    32'hFFFF_FFFF,  FIXED, ST_CLOCK_RANGE, 1'b0);
        row(ACT_RAIL_ON,    32'd10,         FIXED, ST_RAIL_RANGE,  1'b0);
        row(ACT_RAIL_OFF,   32'hFFFF_FFFF,  FIXED, ST_RAIL_RANGE,  1'b0);
        row(ACT_RAIL_ON,    32'd0,          FIXED, ST_RAIL_NONE,   1'b0);
        row(ACT_CLK_ON,     32'd0,          FIXED, ST_OK,          1'b0);
        row(ACT_QUERY,      32'd0,          FIXED, ST_OK,          1'b1);
        row(ACT_CLK_OFF,    32'd0,          FIXED, ST_OK,          1'b0);
        row(ACT_QUERY,      32'd0,          FIXED, ST_OK,          1'b0);
        // two enables then a disable: count above one turns ambiguous
        row(ACT_CLK_ON,     32'd374,        PRED,  ST_OK,          1'b0);
        row(ACT_CLK_ON,     32'd374,        PRED,  ST_OK,          1'b0);
        row(ACT_CLK_OFF,    32'd374,        PRED,  ST_OK,          1'b0);
        row(ACT_QUERY,      32'd374,        FIXED, ST_AMBIGUOUS,   1'b0);
        row(ACT_RAIL_ON,    32'd9,          PRED,  ST_OK,          1'b0);
        // disable of a never-enabled clock marks it known with count zero
        row(ACT_RAIL_OFF,   32'd1,          PRED,  ST_OK,          1'b0);
        row(ACT_QUERY,      32'd187,        FIXED, ST_OK,          1'b0);
        row(ACT_SDC_SEL,    32'd9,          FIXED, ST_OK,          1'b0);
        row(ACT_SDC_SEL,    32'd8,          FIXED, ST_BAD_SEL,     1'b0);
        row(ACT_SDC_SEL,    32'hFFFF_FFFF,  FIXED, ST_BAD_SEL,     1'b0);
        row(ACT_SPARE_A,    32'hFFFF_FFFF,  FIXED, ST_OK,          1'b0);
        row(ACT_SPARE_B,    32'd0,          FIXED, ST_OK,          1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words; the clearing pass after reset holds busy, the
        // handshake wait covers it.
        foreach (dir_rows[j])
        begin
            gap = $urandom_range(1) ? $urandom_range(6, 1) : 0;
            send_word(dir_rows[j].c, dir_rows[j].chk, dir_rows[j].r, gap);
        end

        // Saturation: back-to-back enables to the top of the count, then one
        // more (goes ambiguous) and a disable that must not touch the count.
        wait_results();
        for (int n = 0; n < (1 << CNT_W) - 1; n++)
            send_word({ACT_CLK_ON, SAT_ID}, PRED, '0, 0);
        send_word({ACT_QUERY, SAT_ID}, FIXED, {ST_OK, 1'b1}, 0);
        send_word({ACT_CLK_ON, SAT_ID}, PRED, '0, 0);
        send_word({ACT_CLK_OFF, SAT_ID}, PRED, '0, 0);
        send_word({ACT_QUERY, SAT_ID}, FIXED, {ST_AMBIGUOUS, 1'b0}, 0);

        // Random traffic; the clock window moves every hundred words so fresh
        // entries keep coming after older ones have gone ambiguous.
        base = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
                base = $urandom_range(N_CLK - 1);
            if (i == N_RANDOM / 2)
                wait_results();
            if (i < N_RANDOM - QUIET_TAIL && $urandom_range(3) == 0)
                gap = $urandom_range(6, 1);
            else
                gap = 0;
            send_word(random_word(base), PRED, '0, gap);
        end

        wait_results();
        // keep the clock running after the last result to catch a stray done
        repeat (8) @(posedge clk);

        $display("Ran %0d requests (corners, saturation, random): %0d checked, %0d errors",
                 n_acc, n_checked, n_err);
        $display("Status mix: ok %0d clk %0d rail %0d none %0d ambig %0d unknown %0d sdc %0d",
                 st_seen[ST_OK], st_seen[ST_CLOCK_RANGE], st_seen[ST_RAIL_RANGE],
                 st_seen[ST_RAIL_NONE], st_seen[ST_AMBIGUOUS], st_seen[ST_UNKNOWN],
                 st_seen[ST_BAD_SEL]);
        if (n_err == 0 && results_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial
    begin
        #1ms;
        $display("timeout with %0d result words outstanding", results_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
sv/ceht_pkg.sv
sv/ceht_ram.sv
sv/ceht_front.sv
sv/ceht_queue.sv
sv/ceht_back.sv
sv/clock_enable_hold_tracker.sv
test/clock_enable_hold_tracker_tb.sv
